FILE: rtl/core/mcbq_pkg.sv
// ----------------------------------------------------------------------------
// mcbq_pkg : shared types and constants for the multichannel biquad low-pass
// widths, register indexes, history record and output saturation
// ----------------------------------------------------------------------------
package mcbq_pkg;

	localparam int SAMPLE_BITS   = 24;
	localparam int COEF_BITS     = 24;
	localparam int COEF_FRAC     = 22;
	localparam int NUM_COEFS     = 5;
	localparam int NUM_CHANNELS  = 8;
	localparam int CHAN_BITS     = 3;
	localparam int CFG_ADDR_BITS = 3;

	// product, partial sums and full accumulator widths
	localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
	localparam int FF_BITS    = PROD_BITS + 2;
	localparam int FB_BITS    = PROD_BITS + 1;
	localparam int ACC_BITS   = PROD_BITS + 3;
	localparam int SHIFT_BITS = ACC_BITS - COEF_FRAC;

	// output queue
	localparam int OFIFO_DEPTH = 8;
	localparam int OFIFO_AW    = 3;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_A0 = 3'd0,
		REG_A1 = 3'd1,
		REG_A2 = 3'd2,
		REG_B1 = 3'd3,
		REG_B2 = 3'd4
	} cfg_reg_t;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [PROD_BITS-1:0]   prod_t;

	// one channel's history entry
	typedef struct packed {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} hist_t;

	// one result waiting in the output queue
	typedef struct packed {
		logic [CHAN_BITS-1:0] chan;
		sample_t              sample;
	} res_t;

	// clamp the shifted sum to the sample range
	function automatic sample_t sat_sample(input logic signed [SHIFT_BITS-1:0] v);
		logic [SHIFT_BITS-SAMPLE_BITS:0] top;
		sample_t                         r;
		top = v[SHIFT_BITS-1:SAMPLE_BITS-1];
		if ((&top) || !(|top)) begin
			r = v[SAMPLE_BITS-1:0];
		end else if (v[SHIFT_BITS-1]) begin
			r = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

FILE: rtl/core/multichannel_biquad_lowpass_top.sv
// ----------------------------------------------------------------------------
// multichannel_biquad_lowpass_top : eight-channel direct-form-I biquad
// per-channel history in a small memory, pipelined multiply-accumulate
// ----------------------------------------------------------------------------
// usage
//  - input stream: s_tdata carries the signed sample, s_tuser the channel;
//    a request is taken when s_tvalid and s_tready are both high
//  - output stream: m_tdata carries the filtered, saturated sample and
//    m_tuser the channel it belongs to, in the order the requests came in
//  - coefficients a0, a1, a2, b1, b2 (signed Q2.22) are written through
//    cfg_we / cfg_addr / cfg_wdata while the stream is idle; other indexes
//    are ignored
//  - a taken request passes stages 1, 2 and 3, then the output queue
//  - throughput: one request per cycle while the queue has room and each
//    request's channel differs from all still in flight; a channel cannot
//    follow itself until the read-multiply-sum-writeback loop through the
//    history memory is done (s_tready drops while the channel is in flight)
//  - a stalled receiver does not stop the pipeline: results collect in an
//    eight-entry output queue and s_tready also drops when every queue slot
//    is spoken for by results queued or still in the pipe
//  - reset clears every channel's history (valid bit per entry, no sweep)
//    and returns every coefficient to zero
// ----------------------------------------------------------------------------
module multichannel_biquad_lowpass_top
	import mcbq_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write port
	input  logic                     cfg_we,
	input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
	input  logic [COEF_BITS-1:0]     cfg_wdata,
	// input stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [SAMPLE_BITS-1:0]   s_tdata,  // [23:0] sample_in
	input  logic [CHAN_BITS-1:0]     s_tuser,  // [2:0] chan
	// output stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [SAMPLE_BITS-1:0]   m_tdata,  // [23:0] sample_out
	output logic [CHAN_BITS-1:0]     m_tuser   // [2:0] chan_out
);

	// coefficient registers
	coef_t coef_q [NUM_COEFS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_A0:  coef_q[REG_A0] <= cfg_wdata;
				REG_A1:  coef_q[REG_A1] <= cfg_wdata;
				REG_A2:  coef_q[REG_A2] <= cfg_wdata;
				REG_B1:  coef_q[REG_B1] <= cfg_wdata;
				REG_B2:  coef_q[REG_B2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// history memory, one record per channel, valid bits stand in for clearing
	hist_t                    hist_mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]  hist_vld_q;

	// pipeline registers
	logic                     v_s1, v_s2, v_s3;
	logic [CHAN_BITS-1:0]     chan_s1, chan_s2, chan_s3;
	sample_t                  x_s1, x_s2, x_s3;
	hist_t                    rd_s1;
	logic                     rd_vld_s1;
	sample_t                  x1_s2, y1_s2, x1_s3, y1_s3;
	prod_t                    a0_p_s2, a1_p_s2, a2_p_s2, b1_p_s2, b2_p_s2;
	logic signed [FF_BITS-1:0] ff_s3;
	logic signed [FB_BITS-1:0] fb_s3;

	// output queue and request accounting
	res_t                     ofifo_q [OFIFO_DEPTH];
	logic [OFIFO_AW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [OFIFO_AW:0]        cnt_q;
	logic [OFIFO_AW:0]        pend_q;   // requests taken, results not yet delivered

	logic                     hazard;
	logic                     in_acc;
	logic                     out_acc;
	hist_t                    hist_s1;
	logic signed [ACC_BITS-1:0] acc_s3;
	sample_t                  y_s3;

	// hold a request whose channel still has a history update in flight
	assign hazard = (v_s1 && (chan_s1 == s_tuser)) ||
			(v_s2 && (chan_s2 == s_tuser)) ||
			(v_s3 && (chan_s3 == s_tuser));

	assign s_tready = (pend_q < (OFIFO_AW+1)'(OFIFO_DEPTH)) && !hazard;
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = (cnt_q != '0);
	assign out_acc  = m_tvalid && m_tready;
	assign m_tdata  = ofifo_q[rd_ptr_q].sample;
	assign m_tuser  = ofifo_q[rd_ptr_q].chan;

	// stage 1: registered memory read, never-written entries read as zero
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_s1 <= hist_mem[s_tuser];
		end
		if (v_s3) begin
			hist_mem[chan_s3] <= '{x1: x_s3, x2: x1_s3, y1: y_s3, y2: y1_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (v_s3) begin
				hist_vld_q[chan_s3] <= 1'b1;
			end
			v_s1 <= in_acc;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (in_acc) begin
				rd_vld_s1 <= hist_vld_q[s_tuser];
			end
		end
	end

	assign hist_s1 = rd_vld_s1 ? rd_s1 : '0;

	// payload through the stages
	always_ff @(posedge clk) begin
		if (in_acc) begin
			chan_s1 <= s_tuser;
			x_s1    <= s_tdata;
		end
		// stage 2: five products
		chan_s2 <= chan_s1;
		x_s2    <= x_s1;
		x1_s2   <= hist_s1.x1;
		y1_s2   <= hist_s1.y1;
		a0_p_s2 <= coef_q[REG_A0] * x_s1;
		a1_p_s2 <= coef_q[REG_A1] * hist_s1.x1;
		a2_p_s2 <= coef_q[REG_A2] * hist_s1.x2;
		b1_p_s2 <= coef_q[REG_B1] * hist_s1.y1;
		b2_p_s2 <= coef_q[REG_B2] * hist_s1.y2;
		// stage 3: feedforward and feedback partial sums
		chan_s3 <= chan_s2;
		x_s3    <= x_s2;
		x1_s3   <= x1_s2;
		y1_s3   <= y1_s2;
		ff_s3   <= FF_BITS'(a0_p_s2) + FF_BITS'(a1_p_s2) + FF_BITS'(a2_p_s2);
		fb_s3   <= FB_BITS'(b1_p_s2) + FB_BITS'(b2_p_s2);
	end

	// stage 3 result: difference, floor shift by the coefficient fraction, clamp
	assign acc_s3 = ACC_BITS'(ff_s3) - ACC_BITS'(fb_s3);
	assign y_s3   = sat_sample(acc_s3[ACC_BITS-1:COEF_FRAC]);

	// output queue
	always_ff @(posedge clk) begin
		if (v_s3) begin
			ofifo_q[wr_ptr_q] <= '{chan: chan_s3, sample: y_s3};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			pend_q   <= '0;
		end else begin
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (out_acc) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q  <= cnt_q + (OFIFO_AW+1)'(v_s3) - (OFIFO_AW+1)'(out_acc);
			pend_q <= pend_q + (OFIFO_AW+1)'(in_acc) - (OFIFO_AW+1)'(out_acc);
		end
	end

`ifndef SYNTH
	// queue never takes a result it has no room for
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(v_s3 && !out_acc && (cnt_q == (OFIFO_AW+1)'(OFIFO_DEPTH))))
		else $error("output queue overflow");

	// outstanding count matches the pipe plus the queue
	a_pend_match: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == cnt_q + (OFIFO_AW+1)'(v_s1) + (OFIFO_AW+1)'(v_s2)
			+ (OFIFO_AW+1)'(v_s3))
		else $error("request accounting mismatch");

	// no two in-flight requests share a channel
	a_no_chan_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 |-> chan_s1 != chan_s2) and
		(v_s1 && v_s3 |-> chan_s1 != chan_s3) and
		(v_s2 && v_s3 |-> chan_s2 != chan_s3))
		else $error("history hazard: channel in flight twice");

	// write-back marks the channel history valid
	a_vld_set: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |=> hist_vld_q[$past(chan_s3)])
		else $error("history valid bit not set");
`endif

endmodule
